// File: src/ohss_pkg.sv
`timescale 1ns / 1ps

package ohss_pkg;

  localparam int unsigned CountWidth   = 16;
  localparam int unsigned PhaseWidth   = 3;
  localparam int unsigned PatternWidth = 4;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned OutDepth     = 2;

  localparam int unsigned SnapInterval = 32;

  localparam logic [PhaseWidth-1:0] PhaseLast = PhaseWidth'(7);

  localparam logic [PatternWidth-1:0] CcwTable [8] = '{
    4'h9, 4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8
  };
  localparam logic [PatternWidth-1:0] CwTable [8] = '{
    4'h8, 4'hc, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1, 4'h9
  };

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_STEPS_PER_SWEEP = 2'd0,
    REG_START_CLOCKWISE = 2'd1,
    REG_RUNNING         = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [CountWidth-1:0] steps_per_sweep;
    logic                  start_clockwise;
    logic                  running;
  } cfg_t;

  typedef struct packed {
    logic [PhaseWidth-1:0]   phase_index;
    logic [CountWidth-1:0]   remaining_cycles;
    logic                    direction_cw;
    logic [PatternWidth-1:0] last_pattern;
  } state_t;

  typedef struct packed {
    logic [PatternWidth-1:0] coil_pattern;
    logic                    coil_update;
    logic                    moving_clockwise;
    logic                    snap_valid;
    logic [CountWidth-1:0]   snap_remaining;
  } result_t;

  // trailing zero count of the snap interval
  function automatic int unsigned snap_shift_f(int unsigned value);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 13; i++) begin
      if (((value >> n) & 1) == 0) begin
        n = n + 1;
      end
    end
    return n;
  endfunction

  // inverse of an odd value modulo 2^16, newton steps
  function automatic logic [CountWidth-1:0] inv_odd_f(logic [CountWidth-1:0] m);
    logic [CountWidth-1:0] inv;
    inv = m;
    for (int i = 0; i < 4; i++) begin
      inv = CountWidth'(inv * CountWidth'(CountWidth'(2) - CountWidth'(m * inv)));
    end
    return inv;
  endfunction

  localparam int unsigned SnapShift = snap_shift_f(SnapInterval);
  localparam logic [CountWidth-1:0] SnapOdd  = CountWidth'(SnapInterval >> SnapShift);
  localparam logic [CountWidth-1:0] SnapInv  = inv_odd_f(SnapOdd);
  localparam logic [CountWidth-1:0] SnapMask = CountWidth'((1 << SnapShift) - 1);
  localparam logic [CountWidth-1:0] SnapLimit =
    CountWidth'(((1 << CountWidth) - 1) / (SnapInterval >> SnapShift));

  // exact divisibility by the snap interval: power-of-two part by mask,
  // odd part by multiply with its modular inverse
  function automatic logic snap_due_f(logic [CountWidth-1:0] value);
    logic [CountWidth-1:0] odd_part;
    logic [CountWidth-1:0] prod;
    odd_part = value >> SnapShift;
    prod     = CountWidth'(odd_part * SnapInv);
    return ((value & SnapMask) == '0) && (prod <= SnapLimit);
  endfunction

endpackage

// File: src/ohss_step.sv
`timescale 1ns / 1ps

module ohss_step (
  input  ohss_pkg::state_t  state_i,
  input  ohss_pkg::cfg_t    cfg_i,
  input  logic              tick_i,
  output ohss_pkg::state_t  state_o,
  output ohss_pkg::result_t result_o
);

  logic                                fire;
  logic                                wrap;
  logic [ohss_pkg::PatternWidth-1:0]   pattern;
  logic                                snap;

  assign fire = tick_i & cfg_i.running;
  assign wrap = (state_i.phase_index == ohss_pkg::PhaseLast);
  assign pattern = state_i.direction_cw ? ohss_pkg::CwTable[state_i.phase_index]
                                        : ohss_pkg::CcwTable[state_i.phase_index];
  assign snap = fire & wrap & (state_i.remaining_cycles != '0) &
                ohss_pkg::snap_due_f(state_i.remaining_cycles);

  always_comb begin
    state_o = state_i;
    if (fire) begin
      state_o.last_pattern = pattern;
      if (!wrap) begin
        state_o.phase_index = state_i.phase_index + ohss_pkg::PhaseWidth'(1);
      end else begin
        state_o.phase_index = '0;
        if (state_i.remaining_cycles == '0) begin
          state_o.direction_cw     = ~state_i.direction_cw;
          state_o.remaining_cycles = cfg_i.steps_per_sweep;
        end else begin
          state_o.remaining_cycles = state_i.remaining_cycles - ohss_pkg::CountWidth'(1);
        end
      end
    end
  end

  always_comb begin
    result_o.coil_pattern     = state_o.last_pattern;
    result_o.coil_update      = fire;
    result_o.moving_clockwise = state_o.direction_cw;
    result_o.snap_valid       = snap;
    result_o.snap_remaining   = snap ? state_i.remaining_cycles : '0;
  end

endmodule

// File: src/ohss_out_buf.sv
`timescale 1ns / 1ps

module ohss_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ohss_pkg::result_t result_i,
  input  logic              pop_i,
  output ohss_pkg::result_t result_o,
  output logic              valid_o,
  output logic              full_o
);

  localparam int unsigned PtrWidth = $clog2(ohss_pkg::OutDepth);

  ohss_pkg::result_t          mem_q [ohss_pkg::OutDepth];
  logic [PtrWidth-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]        rd_ptr_q, rd_ptr_d;
  logic [PtrWidth:0]          count_q, count_d;

  assign valid_o  = (count_q != '0);
  assign full_o   = (count_q == (PtrWidth+1)'(ohss_pkg::OutDepth));
  assign result_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrWidth'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrWidth'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (PtrWidth+1)'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - (PtrWidth+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= result_i;
    end
  end

endmodule

// File: src/oscillating_half_step_sequencer_core.sv
`timescale 1ns / 1ps

// Half-step sequencer for a four-coil stepper that sweeps back and forth.
// One tick transfer is taken every clock cycle while in_stall_o is low, and
// each one yields exactly one result: the input register holds the transfer,
// then its result is written to the result buffer. The rate is set by the
// update of the phase, sweep count and direction registers, which every tick
// reads and writes. A two-entry result buffer lets ticks keep flowing while a
// result waits to be taken. Any register write reloads the sweep count and
// direction; write registers only while no tick is in flight.

module oscillating_half_step_sequencer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ohss_pkg::CfgIdxWidth-1:0]    cfg_index_i,
  input  logic [ohss_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                tick_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ohss_pkg::PatternWidth-1:0]   coil_pattern_o,
  output logic                                coil_update_o,
  output logic                                moving_clockwise_o,
  output logic                                snap_valid_o,
  output logic [ohss_pkg::CountWidth-1:0]     snap_remaining_o
);

  ohss_pkg::cfg_t    cfg_q, cfg_d;
  ohss_pkg::state_t  state_q, state_d, state_next;
  ohss_pkg::result_t result, buf_result;
  logic              in_valid_q;
  logic              tick_q;
  logic              buf_full;
  logic              advance;
  logic              in_load;
  logic              pop;

  assign in_stall_o = in_valid_q & buf_full;
  assign in_load    = ~in_stall_o;
  assign advance    = in_valid_q & ~buf_full;
  assign pop        = out_valid_o & ~out_stall_i;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      tick_q <= tick_i;
    end
  end

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        ohss_pkg::REG_STEPS_PER_SWEEP: cfg_d.steps_per_sweep = cfg_data_i;
        ohss_pkg::REG_START_CLOCKWISE: cfg_d.start_clockwise = cfg_data_i[0];
        ohss_pkg::REG_RUNNING:         cfg_d.running         = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  ohss_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .tick_i   (tick_q),
    .state_o  (state_next),
    .result_o (result)
  );

  always_comb begin
    state_d = state_q;
    if (cfg_we_i && (cfg_index_i == ohss_pkg::REG_STEPS_PER_SWEEP ||
                     cfg_index_i == ohss_pkg::REG_START_CLOCKWISE ||
                     cfg_index_i == ohss_pkg::REG_RUNNING)) begin
      state_d.remaining_cycles = cfg_d.steps_per_sweep;
      state_d.direction_cw     = cfg_d.start_clockwise;
    end else if (advance) begin
      state_d = state_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q   <= '0;
      state_q <= '0;
    end else begin
      cfg_q   <= cfg_d;
      state_q <= state_d;
    end
  end

  ohss_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (advance),
    .result_i (result),
    .pop_i    (pop),
    .result_o (buf_result),
    .valid_o  (out_valid_o),
    .full_o   (buf_full)
  );

  assign coil_pattern_o     = buf_result.coil_pattern;
  assign coil_update_o      = buf_result.coil_update;
  assign moving_clockwise_o = buf_result.moving_clockwise;
  assign snap_valid_o       = buf_result.snap_valid;
  assign snap_remaining_o   = buf_result.snap_remaining;

endmodule

// File: src/ohss_checker.sv
`timescale 1ns / 1ps

module ohss_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [ohss_pkg::PatternWidth-1:0]   coil_pattern_o,
  input logic                                coil_update_o,
  input logic                                moving_clockwise_o,
  input logic                                snap_valid_o,
  input logic [ohss_pkg::CountWidth-1:0]     snap_remaining_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(coil_pattern_o) &&
      $stable(coil_update_o) && $stable(moving_clockwise_o) &&
      $stable(snap_valid_o) && $stable(snap_remaining_o))
    else $error("stalled result changed");

  // a snap only happens on a driven step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && snap_valid_o |-> coil_update_o && (snap_remaining_o != '0))
    else $error("snap without a step or with zero count");

  // a result without a snap reports a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !snap_valid_o |-> (snap_remaining_o == '0))
    else $error("count reported without snap");

  // every driven pattern energises at least one coil
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && coil_update_o |-> (coil_pattern_o != '0))
    else $error("driven pattern is empty");

endmodule

bind oscillating_half_step_sequencer_core ohss_checker u_ohss_checker (.*);
